// File: rtl/quaternion_arithmetic_unit_core_assert.svh
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit - assertion macros
// Shared concurrent check wrappers, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// Check on every edge outside reset.
`define QAU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("qau: check failed");

// Check on every edge, reset included.
`define QAU_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("qau: check failed");

`endif

// File: rtl/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Widths, operation and status codes, and the item record that travels
// down the quaternion unit pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int SC_W       = WORD_W - 1;
    localparam int LANES      = 4;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int SQ_W       = PROD_W + 1;
    localparam int ROOT_W     = WORD_W;
    localparam int SQRT_STEPS = PROD_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int TMP_W      = REM_W + 2;
    localparam int NUM_W      = WORD_W + FRAC_W;
    localparam int DIV_STEPS  = NUM_W;

    localparam logic [WORD_W-1:0] MAX_WORD = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] MIN_WORD = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic [3:0] OP_ADD       = 4'd0;
    localparam logic [3:0] OP_SUB       = 4'd1;
    localparam logic [3:0] OP_NEG       = 4'd2;
    localparam logic [3:0] OP_SCALE     = 4'd3;
    localparam logic [3:0] OP_DIVS      = 4'd4;
    localparam logic [3:0] OP_HAMILTON  = 4'd5;
    localparam logic [3:0] OP_CONJ      = 4'd6;
    localparam logic [3:0] OP_NORM2     = 4'd7;
    localparam logic [3:0] OP_NORM      = 4'd8;
    localparam logic [3:0] OP_INVERSE   = 4'd9;
    localparam logic [3:0] OP_NORMALIZE = 4'd10;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    typedef logic [LANES-1:0][WORD_W-1:0] t_quat;

    typedef struct packed {
        logic [3:0]              op;
        t_quat                   r;
        logic [SC_W-1:0]         sc;
        logic                    sat;
        logic                    dz;
        logic [PROD_W-1:0]       sumsq;
        logic                    sq_over;
        t_quat                   mag;
        logic [LANES-1:0]        neg;
        logic [WORD_W-1:0]       cmag;
    } t_item;

endpackage

`default_nettype wire

// File: rtl/qau_front.sv
// ----------------------------------------------------------------------------
// qau_front
// Four-stage front end: operand capture, 16 products plus simple ops,
// sums of products, rounding and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qau_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [3:0]     i_op,
    input  wire qau_pkg::t_quat i_a,
    input  wire qau_pkg::t_quat i_b,
    input  wire logic [31:0]    i_c,
    output logic                o_valid,
    output qau_pkg::t_item      o_item
);
    import qau_pkg::*;

    typedef struct packed {
        logic               sat;
        logic [WORD_W-1:0]  val;
    } t_satw;

    localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_W - 1);
    localparam logic [SQ_W-1:0]  SQ_HALF  = SQ_W'(1) << (FRAC_W - 1);

    function automatic logic [PROD_W-1:0] smul(input logic [WORD_W-1:0] x,
                                               input logic [WORD_W-1:0] y);
        logic signed [WORD_W-1:0] xs;
        logic signed [WORD_W-1:0] ys;
        logic signed [PROD_W-1:0] p;
        xs = x;
        ys = y;
        p  = xs * ys;
        return p;
    endfunction

    function automatic logic [ACC_W-1:0] ext(input logic [PROD_W-1:0] p);
        return {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    function automatic t_satw sat_sum(input logic [WORD_W:0] v);
        t_satw res;
        if (v[WORD_W] != v[WORD_W-1]) begin
            res.sat = 1'b1;
            res.val = v[WORD_W] ? MIN_WORD : MAX_WORD;
        end else begin
            res.sat = 1'b0;
            res.val = v[WORD_W-1:0];
        end
        return res;
    endfunction

    // round half up, drop the fraction, clamp to the word range
    function automatic t_satw round_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] s;
        logic [ACC_W-1:0] t;
        t_satw            res;
        s = acc + ACC_HALF;
        t = {{FRAC_W{s[ACC_W-1]}}, s[ACC_W-1:FRAC_W]};
        if (&t[ACC_W-1:WORD_W-1] || ~|t[ACC_W-1:WORD_W-1]) begin
            res.sat = 1'b0;
            res.val = t[WORD_W-1:0];
        end else begin
            res.sat = 1'b1;
            res.val = s[ACC_W-1] ? MIN_WORD : MAX_WORD;
        end
        return res;
    endfunction

    // stage 1
    logic                              r_v1;
    logic [3:0]                        r_op1;
    t_quat                             r_a1;
    t_quat                             r_b1;
    logic [WORD_W-1:0]                 r_c1;
    // stage 2
    logic                              r_v2;
    logic [LANES-1:0][LANES-1:0][PROD_W-1:0] r_p2, n_p2;
    t_item                             r_item2, n_item2;
    // stage 3
    logic                              r_v3;
    logic [LANES-1:0][ACC_W-1:0]       r_acc3, n_acc3;
    logic [SQ_W-1:0]                   r_sq3, n_sq3;
    t_item                             r_item3;
    // stage 4
    logic                              r_v4;
    t_item                             r_item4, n_item4;

    t_quat             m;
    logic [WORD_W:0]   ax, bx, s33;
    t_satw             sw;
    logic              numneg;
    logic [SQ_W-1:0]   sq_r;
    logic [SQ_W-FRAC_W-1:0] n2_t;
    logic              n2_over;
    t_satw             rnd [LANES];
    logic [LANES-1:0][ACC_W-1:0] ham;

    // stage 2: multiplier operands, simple ops, magnitudes for the divider
    always_comb begin
        case (r_op1)
            OP_SCALE:                                  m = {LANES{r_c1}};
            OP_NORM2, OP_NORM, OP_INVERSE, OP_NORMALIZE: m = r_a1;
            default:                                   m = r_b1;
        endcase
        for (int i = 0; i < LANES; i++) begin
            for (int j = 0; j < LANES; j++) begin
                n_p2[i][j] = smul(r_a1[i], m[j]);
            end
        end

        n_item2      = '0;
        n_item2.op   = r_op1;
        n_item2.cmag = r_c1[WORD_W-1] ? (WORD_W'(0) - r_c1) : r_c1;
        for (int i = 0; i < LANES; i++) begin
            ax = {r_a1[i][WORD_W-1], r_a1[i]};
            bx = {r_b1[i][WORD_W-1], r_b1[i]};
            case (r_op1)
                OP_ADD:  s33 = ax + bx;
                OP_SUB:  s33 = ax - bx;
                OP_NEG:  s33 = '0 - ax;
                OP_CONJ: s33 = (i == 0) ? ax : ('0 - ax);
                default: s33 = '0;
            endcase
            sw = sat_sum(s33);
            n_item2.r[i] = sw.val;
            n_item2.sat  = n_item2.sat | sw.sat;

            n_item2.mag[i] = r_a1[i][WORD_W-1] ? (WORD_W'(0) - r_a1[i]) : r_a1[i];
            // inverse takes the conjugate, so the vector part flips sign
            if (r_op1 == OP_INVERSE && i != 0) begin
                numneg = !r_a1[i][WORD_W-1] && (|r_a1[i]);
            end else begin
                numneg = r_a1[i][WORD_W-1];
            end
            n_item2.neg[i] = numneg ^ ((r_op1 == OP_DIVS) && r_c1[WORD_W-1]);
        end
    end

    // stage 3: Hamilton sums, scale pass-through, sum of squares
    always_comb begin
        ham[0] = ext(r_p2[0][0]) - ext(r_p2[1][1]) - ext(r_p2[2][2]) - ext(r_p2[3][3]);
        ham[1] = ext(r_p2[0][1]) + ext(r_p2[1][0]) + ext(r_p2[2][3]) - ext(r_p2[3][2]);
        ham[2] = ext(r_p2[0][2]) + ext(r_p2[2][0]) + ext(r_p2[3][1]) - ext(r_p2[1][3]);
        ham[3] = ext(r_p2[0][3]) + ext(r_p2[3][0]) + ext(r_p2[1][2]) - ext(r_p2[2][1]);
        for (int i = 0; i < LANES; i++) begin
            n_acc3[i] = (r_item2.op == OP_SCALE) ? ext(r_p2[i][0]) : ham[i];
        end
        n_sq3 = {1'b0, r_p2[0][0]} + {1'b0, r_p2[1][1]}
              + {1'b0, r_p2[2][2]} + {1'b0, r_p2[3][3]};
    end

    // stage 4: round products, squared norm
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            rnd[i] = round_sat(r_acc3[i]);
        end
        sq_r    = r_sq3 + SQ_HALF;
        n2_t    = sq_r[SQ_W-1:FRAC_W];
        n2_over = |n2_t[SQ_W-FRAC_W-1:SC_W];

        n_item4         = r_item3;
        n_item4.sumsq   = r_sq3[PROD_W-1:0];
        n_item4.sq_over = r_sq3[SQ_W-1];
        case (r_item3.op)
            OP_SCALE, OP_HAMILTON: begin
                for (int i = 0; i < LANES; i++) begin
                    n_item4.r[i] = rnd[i].val;
                    n_item4.sat  = n_item4.sat | rnd[i].sat;
                end
            end
            OP_NORM2, OP_INVERSE: begin
                n_item4.sc  = n2_over ? MAX_WORD[SC_W-1:0] : n2_t[SC_W-1:0];
                n_item4.sat = n2_over;
            end
            default: n_item4.sc = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op1   <= i_op;
            r_a1    <= i_a;
            r_b1    <= i_b;
            r_c1    <= i_c;
            r_p2    <= n_p2;
            r_item2 <= n_item2;
            r_acc3  <= n_acc3;
            r_sq3   <= n_sq3;
            r_item3 <= r_item2;
            r_item4 <= n_item4;
        end
    end

    assign o_valid = r_v4;
    assign o_item  = r_item4;

endmodule

`default_nettype wire

// File: rtl/qau_sqrt.sv
// ----------------------------------------------------------------------------
// qau_sqrt
// Pipelined integer square root of the sum of squares, two radicand bits
// per stage, plus a rounding stage that writes the norm into the item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qau_sqrt (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire qau_pkg::t_item i_item,
    output logic                o_valid,
    output qau_pkg::t_item      o_item
);
    import qau_pkg::*;

    localparam int LAST = SQRT_STEPS - 1;

    logic [SQRT_STEPS-1:0] r_v, n_v;
    t_item                 r_item [SQRT_STEPS];
    t_item                 n_item [SQRT_STEPS];
    logic [PROD_W-1:0]     r_x    [SQRT_STEPS];
    logic [PROD_W-1:0]     n_x    [SQRT_STEPS];
    logic [ROOT_W-1:0]     r_root [SQRT_STEPS];
    logic [ROOT_W-1:0]     n_root [SQRT_STEPS];
    logic [REM_W-1:0]      r_rem  [SQRT_STEPS];
    logic [REM_W-1:0]      n_rem  [SQRT_STEPS];

    logic                  r_ov;
    t_item                 r_out, n_out;

    t_item             src_item;
    logic [PROD_W-1:0] src_x;
    logic [ROOT_W-1:0] src_root;
    logic [REM_W-1:0]  src_rem;
    logic [TMP_W-1:0]  tmp, trial, diff;
    logic              ge;
    logic              gt;
    logic [ROOT_W:0]   rnd;
    logic              nsat;

    always_comb begin
        n_v = {r_v[SQRT_STEPS-2:0], i_valid};
        for (int k = 0; k < SQRT_STEPS; k++) begin
            if (k == 0) begin
                src_item = i_item;
                src_x    = i_item.sumsq;
                src_root = '0;
                src_rem  = '0;
            end else begin
                src_item = r_item[k-1];
                src_x    = r_x[k-1];
                src_root = r_root[k-1];
                src_rem  = r_rem[k-1];
            end
            tmp   = {src_rem, src_x[PROD_W-1 -: 2]};
            trial = {{(TMP_W-ROOT_W-2){1'b0}}, src_root, 2'b01};
            diff  = tmp - trial;
            ge    = tmp >= trial;
            n_rem[k]  = ge ? diff[REM_W-1:0] : tmp[REM_W-1:0];
            n_root[k] = {src_root[ROOT_W-2:0], ge};
            n_x[k]    = {src_x[PROD_W-3:0], 2'b00};
            n_item[k] = src_item;
        end
    end

    // round to nearest: bump the root when the remainder passes it
    always_comb begin
        gt    = r_rem[LAST] > {{(REM_W-ROOT_W){1'b0}}, r_root[LAST]};
        rnd   = {1'b0, r_root[LAST]} + {{ROOT_W{1'b0}}, gt};
        nsat  = r_item[LAST].sq_over || (|rnd[ROOT_W:SC_W]);
        n_out = r_item[LAST];
        if (r_item[LAST].op inside {OP_NORM, OP_NORMALIZE}) begin
            n_out.sc  = nsat ? MAX_WORD[SC_W-1:0] : rnd[SC_W-1:0];
            n_out.sat = r_item[LAST].sat | nsat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= n_v;
            r_ov <= r_v[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
            r_x    <= n_x;
            r_root <= n_root;
            r_rem  <= n_rem;
            r_out  <= n_out;
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

endmodule

`default_nettype wire

// File: rtl/qau_div.sv
// ----------------------------------------------------------------------------
// qau_div
// Four-lane pipelined restoring divider with a shared divisor, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qau_div (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_en,
    input  wire logic                                    i_valid,
    input  wire qau_pkg::t_item                          i_item,
    input  wire logic [qau_pkg::WORD_W-1:0]              i_den,
    input  wire logic [qau_pkg::LANES-1:0][qau_pkg::NUM_W-1:0] i_num,
    output logic                                         o_valid,
    output qau_pkg::t_item                               o_item,
    output logic [qau_pkg::LANES-1:0][qau_pkg::NUM_W-1:0] o_quot
);
    import qau_pkg::*;

    localparam int LAST = DIV_STEPS - 1;

    typedef logic [LANES-1:0][NUM_W-1:0]  t_nq;
    typedef logic [LANES-1:0][WORD_W-1:0] t_rem;

    logic [DIV_STEPS-1:0] r_v, n_v;
    t_item                r_item [DIV_STEPS];
    t_item                n_item [DIV_STEPS];
    logic [WORD_W-1:0]    r_den  [DIV_STEPS];
    logic [WORD_W-1:0]    n_den  [DIV_STEPS];
    t_nq                  r_nq   [DIV_STEPS];
    t_nq                  n_nq   [DIV_STEPS];
    t_rem                 r_rem  [DIV_STEPS];
    t_rem                 n_rem  [DIV_STEPS];

    t_item             src_item;
    logic [WORD_W-1:0] src_den;
    t_nq               src_nq;
    t_rem              src_rem;
    logic [WORD_W:0]   tmp, diff;
    logic              ge;

    always_comb begin
        n_v = {r_v[DIV_STEPS-2:0], i_valid};
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                src_item = i_item;
                src_den  = i_den;
                src_nq   = i_num;
                src_rem  = '0;
            end else begin
                src_item = r_item[k-1];
                src_den  = r_den[k-1];
                src_nq   = r_nq[k-1];
                src_rem  = r_rem[k-1];
            end
            for (int l = 0; l < LANES; l++) begin
                tmp  = {src_rem[l], src_nq[l][NUM_W-1]};
                diff = tmp - {1'b0, src_den};
                ge   = tmp >= {1'b0, src_den};
                n_rem[k][l] = ge ? diff[WORD_W-1:0] : tmp[WORD_W-1:0];
                // dividend bits shift out the top, quotient bits in the bottom
                n_nq[k][l]  = {src_nq[l][NUM_W-2:0], ge};
            end
            n_den[k]  = src_den;
            n_item[k] = src_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
            r_den  <= n_den;
            r_nq   <= n_nq;
            r_rem  <= n_rem;
        end
    end

    assign o_valid = r_v[LAST];
    assign o_item  = r_item[LAST];
    assign o_quot  = r_nq[LAST];

endmodule

`default_nettype wire

// File: rtl/quaternion_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_core
// Fully pipelined Q16.16 quaternion unit: add, subtract, negate, scale,
// divide by scalar, Hamilton product, conjugate, squared norm, norm,
// inverse and normalize, with saturation and divide-by-zero status.
// A request is accepted on every clock while o_ready is high, and its
// result reaches o_valid through four front-end stages (products and
// rounding), 33 stages of square root, one divisor setup stage, the
// 48-stage quotient divider, then a two-entry output buffer. Every
// operation takes the full path, so results leave in request order.
// o_ready is a registered flag that drops only while both output buffer
// entries hold unclaimed results; the whole pipeline then holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_arithmetic_unit_core_assert.svh"

module quaternion_arithmetic_unit_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_operation,
    input  wire logic signed [31:0] i_a_real,
    input  wire logic signed [31:0] i_a_i,
    input  wire logic signed [31:0] i_a_j,
    input  wire logic signed [31:0] i_a_k,
    input  wire logic signed [31:0] i_b_real,
    input  wire logic signed [31:0] i_b_i,
    input  wire logic signed [31:0] i_b_j,
    input  wire logic signed [31:0] i_b_k,
    input  wire logic signed [31:0] i_scalar_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [31:0] o_r_real,
    output logic signed [31:0] o_r_i,
    output logic signed [31:0] o_r_j,
    output logic signed [31:0] o_r_k,
    output logic [30:0]      o_scalar_out,
    output logic [1:0]       o_status
);
    import qau_pkg::*;

    typedef struct packed {
        t_quat            r;
        logic [SC_W-1:0]  sc;
        logic [1:0]       status;
    } t_out;

    localparam logic [NUM_W-1:0] POS_LIM = {{(NUM_W-WORD_W){1'b0}}, MAX_WORD};
    localparam logic [NUM_W-1:0] NEG_LIM = {{(NUM_W-WORD_W){1'b0}}, MIN_WORD};

    logic   pipe_en;
    logic   f_valid, s_valid, d_valid;
    t_item  f_item, s_item, d_item;
    logic [LANES-1:0][NUM_W-1:0] d_quot;

    // divisor setup stage
    logic                        r_pv;
    t_item                       r_pitem, n_pitem;
    logic [WORD_W-1:0]           r_pden, n_pden;
    logic [LANES-1:0][NUM_W-1:0] r_pnum, n_pnum;
    logic                        prep_divop;

    // output buffer
    logic [1:0] r_cnt, n_cnt;
    t_out       r_q0, r_q1;
    t_out       fin;
    logic       push, pop, wsel;
    logic       fin_divop;
    logic       qsat;
    t_quat      divr;

    assign pipe_en = (r_cnt != 2'd2);
    assign o_ready = pipe_en;

    qau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_valid),
        .i_op    (i_operation),
        .i_a     ({i_a_k, i_a_j, i_a_i, i_a_real}),
        .i_b     ({i_b_k, i_b_j, i_b_i, i_b_real}),
        .i_c     (i_scalar_in),
        .o_valid (f_valid),
        .o_item  (f_item)
    );

    qau_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (f_valid),
        .i_item  (f_item),
        .o_valid (s_valid),
        .o_item  (s_item)
    );

    // pick the divisor and pre-add half of it for round-half-away
    always_comb begin
        prep_divop = s_item.op inside {OP_DIVS, OP_INVERSE, OP_NORMALIZE};
        n_pden     = (s_item.op == OP_DIVS) ? s_item.cmag : {1'b0, s_item.sc};
        n_pitem    = s_item;
        n_pitem.dz = prep_divop && (n_pden == '0);
        for (int l = 0; l < LANES; l++) begin
            n_pnum[l] = {s_item.mag[l], {FRAC_W{1'b0}}}
                      + {{(NUM_W-WORD_W+1){1'b0}}, n_pden[WORD_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (pipe_en) begin
            r_pv <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_pitem <= n_pitem;
            r_pden  <= n_pden;
            r_pnum  <= n_pnum;
        end
    end

    qau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_pv),
        .i_item  (r_pitem),
        .i_den   (r_pden),
        .i_num   (r_pnum),
        .o_valid (d_valid),
        .o_item  (d_item),
        .o_quot  (d_quot)
    );

    // apply quotient sign, saturate, settle status
    always_comb begin
        fin_divop = d_item.op inside {OP_DIVS, OP_INVERSE, OP_NORMALIZE};
        qsat      = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            if (d_item.neg[l]) begin
                if (d_quot[l] > NEG_LIM) begin
                    divr[l] = MIN_WORD;
                    qsat    = 1'b1;
                end else begin
                    divr[l] = WORD_W'(0) - d_quot[l][WORD_W-1:0];
                end
            end else begin
                if (d_quot[l] > POS_LIM) begin
                    divr[l] = MAX_WORD;
                    qsat    = 1'b1;
                end else begin
                    divr[l] = d_quot[l][WORD_W-1:0];
                end
            end
        end
        fin.sc = d_item.sc;
        if (d_item.dz) begin
            fin.r      = '0;
            fin.status = ST_DZ;
        end else begin
            fin.r = fin_divop ? divr : d_item.r;
            if (d_item.sat || (fin_divop && qsat)) begin
                fin.status = ST_SAT;
            end else begin
                fin.status = ST_OK;
            end
        end
    end

    assign push  = pipe_en && d_valid;
    assign pop   = o_valid && i_ready;
    assign wsel  = (r_cnt == 2'd1) && !pop;
    assign n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        // advance the second entry on a pop from a full buffer
        if (pop && r_cnt == 2'd2) begin
            r_q0 <= r_q1;
        end
        if (push) begin
            if (wsel) begin
                r_q1 <= fin;
            end else begin
                r_q0 <= fin;
            end
        end
    end

    assign o_valid      = (r_cnt != 2'd0);
    assign o_r_real     = r_q0.r[0];
    assign o_r_i        = r_q0.r[1];
    assign o_r_j        = r_q0.r[2];
    assign o_r_k        = r_q0.r[3];
    assign o_scalar_out = r_q0.sc;
    assign o_status     = r_q0.status;

    `QAU_ASSERT(a_cnt_range, r_cnt != 2'd3)
    `QAU_ASSERT(a_full_holds, (r_cnt == 2'd2) |-> !o_ready && !push)
    `QAU_ASSERT(a_dz_zero, o_valid && (o_status == ST_DZ) |-> (r_q0.r == '0))
    `QAU_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_valid)

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quaternion unit: a queue-fed driver sends
// requests in random bursts, a monitor stalls on its own pattern and checks
// every result against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import qau_pkg::*;

    typedef struct {
        logic [3:0]         op;
        logic signed [31:0] a [4];
        logic signed [31:0] b [4];
        logic signed [31:0] s;
    } t_req;

    typedef struct {
        logic signed [31:0] q [4];
        logic [30:0]        sc;
        logic [1:0]         st;
    } t_res;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam int     LATENCY = 87;
    localparam int     CYCLE_LIMIT = 400000;

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    logic [3:0] i_operation;
    logic signed [31:0] i_a_real, i_a_i, i_a_j, i_a_k;
    logic signed [31:0] i_b_real, i_b_i, i_b_j, i_b_k, i_scalar_in;
    logic signed [31:0] o_r_real, o_r_i, o_r_j, o_r_k;
    logic [30:0] o_scalar_out;
    logic [1:0] o_status;

    t_req pending_reqs [$];
    t_res expected_results [$];
    int   mismatches;
    int   cycles;
    bit   hold_sender;
    int   burst_left, gap_left;
    int   stall_phase;

    quaternion_arithmetic_unit_core u_top (.*);

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic longint clamp(longint v, ref bit sat);
        if (v > QMAX) begin sat = 1; return QMAX; end
        if (v < QMIN) begin sat = 1; return QMIN; end
        return v;
    endfunction

    // round a Q32 sum half up, drop fraction bits, clamp
    function automatic longint round_q(logic signed [69:0] acc, longint lo,
                                       ref bit sat);
        logic signed [69:0] t;
        t = (acc + 70'sd32768) >>> FRAC_W;
        if (t > lo + 0 && t > QMAX) begin sat = 1; return QMAX; end
        if (t > QMAX) begin sat = 1; return QMAX; end
        if (t < lo) begin sat = 1; return lo; end
        return longint'(t);
    endfunction

    // quotient rounded half away from zero
    function automatic longint quot(longint num, longint den, ref bit sat);
        logic [95:0] n, d, q;
        n = (num < 0 ? -num : num);
        d = (den < 0 ? -den : den);
        n = n << FRAC_W;
        q = (n + d / 2) / d;
        if ((num < 0) != (den < 0)) return clamp(-longint'(q), sat);
        if (q > QMAX) begin sat = 1; return QMAX; end
        return longint'(q);
    endfunction

    function automatic logic [69:0] sum_squares(t_req r);
        logic [69:0] s;
        s = 0;
        for (int i = 0; i < 4; i++) s += 70'(longint'(r.a[i]) * longint'(r.a[i]));
        return s;
    endfunction

    // the root of a 65-bit sum fits in 33 bits, so its square stays in 70
    function automatic longint root_of(logic [69:0] s, ref bit sat);
        logic [69:0] x, r;
        x = 0;
        for (int bt = 32; bt >= 0; bt--) begin
            r = x | (70'd1 << bt);
            if (r * r <= s) x = r;
        end
        if (s - x * x > x) x++;
        if (x > QMAX) begin sat = 1; return QMAX; end
        return longint'(x);
    endfunction

    function automatic t_res predict_quat(t_req r);
        t_res e;
        longint a [4], b [4], c, n, v [4];
        logic signed [69:0] acc;
        logic [69:0] s;
        bit sat, dz;
        sat = 0; dz = 0; n = 0;
        for (int i = 0; i < 4; i++) begin
            a[i] = r.a[i]; b[i] = r.b[i]; v[i] = 0;
        end
        c = r.s;
        e.sc = 0;
        case (r.op)
            OP_ADD: for (int i = 0; i < 4; i++) v[i] = clamp(a[i] + b[i], sat);
            OP_SUB: for (int i = 0; i < 4; i++) v[i] = clamp(a[i] - b[i], sat);
            OP_NEG: for (int i = 0; i < 4; i++) v[i] = clamp(-a[i], sat);
            OP_SCALE: for (int i = 0; i < 4; i++) v[i] = round_q(70'(a[i] * c), QMIN, sat);
            OP_DIVS: begin
                if (c == 0) dz = 1;
                else for (int i = 0; i < 4; i++) v[i] = quot(a[i], c, sat);
            end
            OP_HAMILTON: begin
                acc = 70'(a[0]*b[0]) - 70'(a[1]*b[1]) - 70'(a[2]*b[2]) - 70'(a[3]*b[3]);
                v[0] = round_q(acc, QMIN, sat);
                acc = 70'(a[0]*b[1]) + 70'(b[0]*a[1]) + 70'(a[2]*b[3]) - 70'(a[3]*b[2]);
                v[1] = round_q(acc, QMIN, sat);
                acc = 70'(a[0]*b[2]) + 70'(b[0]*a[2]) + 70'(a[3]*b[1]) - 70'(a[1]*b[3]);
                v[2] = round_q(acc, QMIN, sat);
                acc = 70'(a[0]*b[3]) + 70'(b[0]*a[3]) + 70'(a[1]*b[2]) - 70'(a[2]*b[1]);
                v[3] = round_q(acc, QMIN, sat);
            end
            OP_CONJ: begin
                v[0] = a[0];
                for (int i = 1; i < 4; i++) v[i] = clamp(-a[i], sat);
            end
            OP_NORM2, OP_NORM, OP_INVERSE, OP_NORMALIZE: begin
                s = sum_squares(r);
                if (r.op == OP_NORM2 || r.op == OP_INVERSE)
                    n = round_q(signed'(s), 0, sat);
                else
                    n = root_of(s, sat);
                e.sc = n[30:0];
                if (r.op == OP_INVERSE || r.op == OP_NORMALIZE) begin
                    if (n == 0) dz = 1;
                    else begin
                        v[0] = quot(a[0], n, sat);
                        for (int i = 1; i < 4; i++)
                            v[i] = quot(r.op == OP_INVERSE ? -a[i] : a[i], n, sat);
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < 4; i++) e.q[i] = dz ? 32'sd0 : v[i][31:0];
        e.st = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
        return e;
    endfunction

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'sd0;
            3, 4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            5, 6: return $signed($urandom_range(0, 32'h7ffffff)) - 32'sh4000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_req(logic [3:0] op, logic signed [31:0] av,
                            logic signed [31:0] bv, logic signed [31:0] sv);
        t_req r;
        r.op = op; r.s = sv;
        for (int i = 0; i < 4; i++) begin r.a[i] = av; r.b[i] = bv; end
        pending_reqs.push_back(r);
    endtask

    // driver: random bursts and gaps, held off while hold_sender is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left <= 0; gap_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() > 0 && !hold_sender) begin
                t_req r;
                r = pending_reqs.pop_front();
                expected_results.push_back(predict_quat(r));
                i_valid <= 1'b1;
                i_operation <= r.op;
                i_a_real <= r.a[0]; i_a_i <= r.a[1]; i_a_j <= r.a[2]; i_a_k <= r.a[3];
                i_b_real <= r.b[0]; i_b_i <= r.b[1]; i_b_j <= r.b[2]; i_b_k <= r.b[3];
                i_scalar_in <= r.s;
                if (burst_left > 0) burst_left <= burst_left - 1;
                else begin
                    burst_left <= $urandom_range(0, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: stall pattern cycles through light, busy and free phases
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_phase <= 0;
            mismatches <= 0;
        end else begin
            stall_phase <= (stall_phase + 1) % 600;
            if (stall_phase < 200) i_ready <= ($urandom_range(0, 3) != 0);
            else if (stall_phase < 400) i_ready <= ($urandom_range(0, 3) == 0);
            else i_ready <= 1'b1;
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("tb: result with nothing expected");
                end else begin
                    t_res e;
                    e = expected_results.pop_front();
                    if (o_r_real !== e.q[0] || o_r_i !== e.q[1] || o_r_j !== e.q[2]
                        || o_r_k !== e.q[3] || o_scalar_out !== e.sc
                        || o_status !== e.st) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("tb: mismatch exp %h %h %h %h %h %0d got %h %h %h %h %h %0d",
                                     e.q[0], e.q[1], e.q[2], e.q[3], e.sc, e.st,
                                     o_r_real, o_r_i, o_r_j, o_r_k, o_scalar_out,
                                     o_status);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_req r;
        cycles = 0;
        hold_sender = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_ready = 1'b0; i_operation = OP_ADD;
        {i_a_real, i_a_i, i_a_j, i_a_k} = '0;
        {i_b_real, i_b_i, i_b_j, i_b_k, i_scalar_in} = '0;

        // directed: every code, extremes, zero divisor and zero norm
        for (int op = 0; op < 16; op++)
            push_req(op[3:0], 32'sh00018000, -32'sh00008000, 32'sh00020000);
        push_req(OP_ADD, 32'sh7fffffff, 32'sh7fffffff, 0);
        push_req(OP_SUB, 32'sh80000000, 32'sh7fffffff, 0);
        push_req(OP_NEG, 32'sh80000000, 0, 0);
        push_req(OP_CONJ, 32'sh80000000, 0, 0);
        push_req(OP_DIVS, 32'sh00010000, 0, 0);
        push_req(OP_DIVS, 32'sh7fffffff, 0, 1);
        push_req(OP_INVERSE, 0, 0, 0);
        push_req(OP_NORMALIZE, 0, 0, 0);
        push_req(OP_HAMILTON, 32'sh80000000, 32'sh80000000, 0);
        push_req(OP_NORM2, 32'sh80000000, 0, 0);
        push_req(OP_INVERSE, 1, 0, 0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < 1600; n++) begin
            r.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                : 4'($urandom_range(0, 10));
            for (int i = 0; i < 4; i++) begin
                r.a[i] = pick_word();
                r.b[i] = pick_word();
            end
            r.s = pick_word();
            pending_reqs.push_back(r);
            if (n == 700) begin
                // drain fully once mid-run
                wait (pending_reqs.size() == 0);
                hold_sender = 1'b1;
                wait (expected_results.size() == 0);
                @(posedge i_clk);
                hold_sender = 1'b0;
            end
        end
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
